[design/colour_blob_selector_defines.svh]
// ----------------------------------------------------------------------------
// Colour blob selector assertion macros
// Shared property wrappers; the including module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef COLOUR_BLOB_SELECTOR_DEFINES_SVH
`define COLOUR_BLOB_SELECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("colour blob selector: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("colour blob selector: next-cycle check failed");

`endif

[design/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// Colour blob selector package
// Widths, register indexes, interface types and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbs_pkg;

  localparam int HUE_STEPS = 1024;
  localparam int MAX_BLOBS = 1024;

  localparam int HUE_W    = $clog2(HUE_STEPS);
  localparam int SAT_W    = 8;
  localparam int SIZE_W   = 20;
  localparam int CH_W     = 8;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int SCORE_W  = 52;
  localparam int Q_W      = 15;
  localparam int VEC_W    = 16;
  localparam int DP_W     = 15;
  localparam int TGT_W    = 2;
  localparam int FIT_W    = 16;
  localparam int GRAY_W   = 8;
  localparam int Q14_SH   = 14;
  localparam int ONE_Q14  = 16384;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_REF_HUE_BLUE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REF_HUE_RED  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REF_HUE_BALL = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CALIBRATED   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_COSINE   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_FIT      = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_GRAY_RATIO   = 3'd7;

  localparam logic [TGT_W-1:0] TGT_BLUE = 2'd0;
  localparam logic [TGT_W-1:0] TGT_RED  = 2'd1;
  localparam logic [TGT_W-1:0] TGT_BALL = 2'd2;

  typedef struct packed {
    logic [HUE_W-1:0]  ref_hue_blue;
    logic [HUE_W-1:0]  ref_hue_red;
    logic [HUE_W-1:0]  ref_hue_ball;
    logic [TGT_W-1:0]  target_colour;
    logic              calibrated;
    logic [DP_W-1:0]   min_cosine;
    logic [FIT_W-1:0]  min_fit;
    logic [GRAY_W-1:0] gray_ratio;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic dot1;
    logic dot2;
    logic dp;
    logic sc1;
    logic sc2;
    logic sc3;
    logic commit;
    logic fit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] c;
    logic signed [VEC_W-1:0] s;
  } vec_t;

  // Hue codes step by a quarter of the table per quadrant, so only every
  // fourth sample of the quarter wave is ever needed.
  localparam int QTAB_DEPTH = HUE_STEPS / 4 + 1;
  localparam int QIDX_W     = $clog2(QTAB_DEPTH);

  typedef logic [Q_W-1:0] qtab_t [QTAB_DEPTH];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SER_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

  // Sine series in Q30, evaluated at elaboration only.
  function automatic logic [Q_W-1:0] quarter_sine(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    x    = (r * HALF_PI_Q30) / HUE_STEPS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / SER_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) + 64'd32768) >> 16;
    if (v > ONE_Q14) begin
      v = ONE_Q14;
    end
    return Q_W'(v);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k < QTAB_DEPTH; k++) begin
      t[k] = quarter_sine(longint'(4 * k));
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Unit vector (cos, sin) of a hue code in Q1.14.
  function automatic vec_t hue_vector(logic [HUE_W-1:0] h);
    logic [1:0]              q;
    logic [QIDX_W-1:0]       ka;
    logic [QIDX_W-1:0]       kb;
    logic signed [VEC_W-1:0] a;
    logic signed [VEC_W-1:0] b;
    vec_t                    v;
    q  = h[HUE_W-1 -: 2];
    ka = QIDX_W'(h[HUE_W-3:0]);
    kb = QIDX_W'(QTAB_DEPTH - 1) - ka;
    a  = $signed(VEC_W'(QTAB[ka]));
    b  = $signed(VEC_W'(QTAB[kb]));
    unique case (q)
      2'd0: begin v.s = a;  v.c = b;  end
      2'd1: begin v.s = b;  v.c = -a; end
      2'd2: begin v.s = -a; v.c = -b; end
      2'd3: begin v.s = -b; v.c = a;  end
    endcase
    return v;
  endfunction

endpackage

[design/colour_blob_selector.sv]
// ----------------------------------------------------------------------------
// Colour blob selector
// Picks the blob of a list whose hue best matches a calibrated reference.
// ----------------------------------------------------------------------------
// Each blob transaction holds the block through DOT1, DOT2, DP, SC1, SC2, SC3
// and COMMIT, with in_tready low, so a new blob is taken only when the last is
// done. One multiplier is shared in turn by the two products of the hue dot
// product and the three products of the score dp*S*S*size, with a register
// stage between each. A blob marked with tlast then passes FIT (the min_fit *
// largest size product) and EMIT (the result load) and then one result
// transaction is issued; if the previous result has not yet been taken, the
// block waits for it before loading the new one. Configuration writes take
// effect at once and must be made only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module colour_blob_selector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // hue[9:0], saturation[17:10], blob_size[37:18], red[45:38], green[53:46],
  // blue[61:54], zero[63:62]
  input  logic [cbs_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // blob_index[9:0], blob_count[20:10], zero[23:21]
  output logic [cbs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // found[0]
  output logic                               out_tuser,
  input  logic                               cfg_we,
  input  logic [cbs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  cbs_pkg::cfg_t cfg;
  cbs_pkg::cmd_t cmd;
  cbs_pkg::sts_t sts;

  cbs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[design/cbs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Colour blob selector configuration registers
// Write-only register bank loaded from the plain configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cbs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output cbs_pkg::cfg_t                    cfg
);

  cbs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_hue_blue  <= cbs_pkg::HUE_W'(683);
      cfg_r.ref_hue_red   <= '0;
      cfg_r.ref_hue_ball  <= cbs_pkg::HUE_W'(171);
      cfg_r.target_colour <= cbs_pkg::TGT_BLUE;
      cfg_r.calibrated    <= 1'b0;
      cfg_r.min_cosine    <= cbs_pkg::DP_W'(14746);
      cfg_r.min_fit       <= cbs_pkg::FIT_W'(1638);
      cfg_r.gray_ratio    <= cbs_pkg::GRAY_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cbs_pkg::REG_REF_HUE_BLUE: cfg_r.ref_hue_blue  <= cfg_wdata[cbs_pkg::HUE_W-1:0];
        cbs_pkg::REG_REF_HUE_RED:  cfg_r.ref_hue_red   <= cfg_wdata[cbs_pkg::HUE_W-1:0];
        cbs_pkg::REG_REF_HUE_BALL: cfg_r.ref_hue_ball  <= cfg_wdata[cbs_pkg::HUE_W-1:0];
        cbs_pkg::REG_TARGET:       cfg_r.target_colour <= cfg_wdata[cbs_pkg::TGT_W-1:0];
        cbs_pkg::REG_CALIBRATED:   cfg_r.calibrated    <= cfg_wdata[0];
        cbs_pkg::REG_MIN_COSINE:   cfg_r.min_cosine    <= cfg_wdata[cbs_pkg::DP_W-1:0];
        cbs_pkg::REG_MIN_FIT:      cfg_r.min_fit       <= cfg_wdata[cbs_pkg::FIT_W-1:0];
        cbs_pkg::REG_GRAY_RATIO:   cfg_r.gray_ratio    <= cfg_wdata[cbs_pkg::GRAY_W-1:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/cbs_ctrl.sv]
// ----------------------------------------------------------------------------
// Colour blob selector controller
// Sequences one blob through the shared multiplier and issues the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "colour_blob_selector_defines.svh"

module cbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cbs_pkg::sts_t sts,
  output cbs_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DOT1   = 4'd1;
  localparam logic [3:0] S_DOT2   = 4'd2;
  localparam logic [3:0] S_DP     = 4'd3;
  localparam logic [3:0] S_SC1    = 4'd4;
  localparam logic [3:0] S_SC2    = 4'd5;
  localparam logic [3:0] S_SC3    = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;
  localparam logic [3:0] S_FIT    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.capture = in_tvalid && in_tready;
    cmd.dot1    = (state_r == S_DOT1);
    cmd.dot2    = (state_r == S_DOT2);
    cmd.dp      = (state_r == S_DP);
    cmd.sc1     = (state_r == S_SC1);
    cmd.sc2     = (state_r == S_SC2);
    cmd.sc3     = (state_r == S_SC3);
    cmd.commit  = (state_r == S_COMMIT);
    cmd.fit     = (state_r == S_FIT);
    cmd.emit    = (state_r == S_EMIT) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_DOT1;
      S_DOT1:   state_nxt = S_DOT2;
      S_DOT2:   state_nxt = S_DP;
      S_DP:     state_nxt = S_SC1;
      S_SC1:    state_nxt = S_SC2;
      S_SC2:    state_nxt = S_SC3;
      S_SC3:    state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = sts.last ? S_FIT : S_IDLE;
      S_FIT:    state_nxt = S_EMIT;
      S_EMIT:   if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // At most one datapath step is commanded in any cycle.
  `CBS_ASSERT_NOW(a_one_step, 1'b1, $onehot0(cmd))
  // An accepted transaction always starts the dot product next.
  `CBS_ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, state_r == S_DOT1)
  // Loading a result always returns the controller to idle.
  `CBS_ASSERT_NEXT(a_emit_idle, cmd.emit, state_r == S_IDLE)

endmodule

[design/cbs_datapath.sv]
// ----------------------------------------------------------------------------
// Colour blob selector datapath
// Hue vectors, greyness test, shared multiplier, running argmax and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "colour_blob_selector_defines.svh"

module cbs_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cbs_pkg::cfg_t                      cfg,
  input  cbs_pkg::cmd_t                      cmd,
  output cbs_pkg::sts_t                      sts,
  input  logic [cbs_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cbs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);

  localparam int MA_W  = 33;
  localparam int MB_W  = 21;
  localparam int ACC_W = MA_W + MB_W;
  localparam int RND_W = 18;

  // Input field positions inside tdata.
  localparam int HUE_LSB  = 0;
  localparam int SAT_LSB  = HUE_LSB + cbs_pkg::HUE_W;
  localparam int SIZE_LSB = SAT_LSB + cbs_pkg::SAT_W;
  localparam int RED_LSB  = SIZE_LSB + cbs_pkg::SIZE_W;
  localparam int GRN_LSB  = RED_LSB + cbs_pkg::CH_W;
  localparam int BLU_LSB  = GRN_LSB + cbs_pkg::CH_W;

  logic [cbs_pkg::HUE_W-1:0]  in_hue;
  logic [cbs_pkg::SAT_W-1:0]  in_sat;
  logic [cbs_pkg::SIZE_W-1:0] in_size;
  logic [cbs_pkg::CH_W-1:0]   in_red;
  logic [cbs_pkg::CH_W-1:0]   in_green;
  logic [cbs_pkg::CH_W-1:0]   in_blue;

  logic [cbs_pkg::HUE_W-1:0]  ref_hue;
  cbs_pkg::vec_t              blob_vec;
  cbs_pkg::vec_t              ref_vec;
  logic                       grey;
  logic                       counted;

  // Captured item and list state.
  cbs_pkg::vec_t               blob_vec_r;
  cbs_pkg::vec_t               ref_vec_r;
  logic [cbs_pkg::SAT_W-1:0]   sat_r;
  logic [cbs_pkg::SIZE_W-1:0]  size_r;
  logic                        last_r;
  logic [cbs_pkg::IDX_W-1:0]   pos_r;
  logic                        elig_r;
  logic [cbs_pkg::DP_W-1:0]    dp_r;
  logic                        pass_r;
  logic signed [ACC_W-1:0]     acc_r;

  logic [cbs_pkg::CNT_W-1:0]   items_seen_r;
  logic [cbs_pkg::SIZE_W-1:0]  largest_r;
  logic [cbs_pkg::SCORE_W-1:0] best_r;
  logic [cbs_pkg::IDX_W-1:0]   best_pos_r;
  logic                        have_r;

  logic                        out_valid_r;
  logic                        found_r;
  logic [cbs_pkg::IDX_W-1:0]   index_r;
  logic [cbs_pkg::CNT_W-1:0]   count_r;

  logic signed [MA_W-1:0]      op_a;
  logic signed [MB_W-1:0]      op_b;
  logic signed [ACC_W-1:0]     mul_p;
  logic [RND_W-1:0]            dp_full;
  logic [cbs_pkg::DP_W-1:0]    dp_clamp;
  logic [cbs_pkg::SCORE_W-1:0] score;
  logic [cbs_pkg::SCORE_W-1:0] fit_thr;
  logic                        found;

  function automatic logic close_pair(logic [cbs_pkg::CH_W-1:0]   a,
                                      logic [cbs_pkg::CH_W-1:0]   b,
                                      logic [cbs_pkg::GRAY_W-1:0] ratio);
    logic [cbs_pkg::CH_W-1:0] d;
    logic [cbs_pkg::CH_W-1:0] m;
    d = (a > b) ? (a - b) : (b - a);
    m = (a < b) ? a : b;
    return {d, 8'd0} < (16'(ratio) * 16'(m));
  endfunction

  assign in_hue   = in_tdata[HUE_LSB  +: cbs_pkg::HUE_W];
  assign in_sat   = in_tdata[SAT_LSB  +: cbs_pkg::SAT_W];
  assign in_size  = in_tdata[SIZE_LSB +: cbs_pkg::SIZE_W];
  assign in_red   = in_tdata[RED_LSB  +: cbs_pkg::CH_W];
  assign in_green = in_tdata[GRN_LSB  +: cbs_pkg::CH_W];
  assign in_blue  = in_tdata[BLU_LSB  +: cbs_pkg::CH_W];

  always_comb begin
    unique case (cfg.target_colour)
      cbs_pkg::TGT_BLUE: ref_hue = cfg.ref_hue_blue;
      cbs_pkg::TGT_RED:  ref_hue = cfg.ref_hue_red;
      default:           ref_hue = cfg.ref_hue_ball;
    endcase
  end

  assign blob_vec = cbs_pkg::hue_vector(in_hue);
  assign ref_vec  = cbs_pkg::hue_vector(ref_hue);
  assign grey     = close_pair(in_red, in_green, cfg.gray_ratio) &&
                    close_pair(in_red, in_blue, cfg.gray_ratio) &&
                    close_pair(in_green, in_blue, cfg.gray_ratio);
  assign counted  = items_seen_r < cbs_pkg::CNT_W'(cbs_pkg::MAX_BLOBS);

  // Operand selection for the one shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    priority if (cmd.dot1) begin
      op_a = MA_W'(blob_vec_r.c);
      op_b = MB_W'(ref_vec_r.c);
    end else if (cmd.dot2) begin
      op_a = MA_W'(blob_vec_r.s);
      op_b = MB_W'(ref_vec_r.s);
    end else if (cmd.sc1) begin
      op_a = $signed(MA_W'(dp_r));
      op_b = $signed(MB_W'(sat_r));
    end else if (cmd.sc2) begin
      op_a = $signed(acc_r[MA_W-1:0]);
      op_b = $signed(MB_W'(sat_r));
    end else if (cmd.sc3) begin
      op_a = $signed(acc_r[MA_W-1:0]);
      op_b = $signed(MB_W'(size_r));
    end else if (cmd.fit) begin
      op_a = $signed(MA_W'(cfg.min_fit));
      op_b = $signed(MB_W'(largest_r));
    end
  end

  assign mul_p = op_a * op_b;

  // The dot product never exceeds 2^29, so the low 32 bits carry it whole.
  assign dp_full  = RND_W'((acc_r[31:0] + 32'd8192) >> cbs_pkg::Q14_SH);
  assign dp_clamp = (dp_full > RND_W'(cbs_pkg::ONE_Q14)) ?
                    cbs_pkg::DP_W'(cbs_pkg::ONE_Q14) : dp_full[cbs_pkg::DP_W-1:0];

  assign score   = acc_r[cbs_pkg::SCORE_W-1:0];
  assign fit_thr = cbs_pkg::SCORE_W'({acc_r[cbs_pkg::FIT_W+cbs_pkg::SIZE_W-1:0],
                                      {cbs_pkg::Q14_SH{1'b0}}});
  assign found   = cfg.calibrated && have_r && (best_r > fit_thr);

  // Item pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blob_vec_r <= blob_vec;
      ref_vec_r  <= ref_vec;
      sat_r      <= in_sat;
      size_r     <= in_size;
      last_r     <= in_tlast;
      pos_r      <= items_seen_r[cbs_pkg::IDX_W-1:0];
      elig_r     <= counted && (cfg.target_colour <= cbs_pkg::TGT_BALL) && !grey;
    end
    if (cmd.dot1 || cmd.sc1 || cmd.sc2 || cmd.sc3 || cmd.fit) begin
      acc_r <= mul_p;
    end else if (cmd.dot2) begin
      acc_r <= acc_r + mul_p;
    end
    if (cmd.dp) begin
      dp_r   <= dp_clamp;
      pass_r <= elig_r && !acc_r[ACC_W-1] && (dp_clamp > cfg.min_cosine);
    end
  end

  // List state, cleared by reset and after each result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      items_seen_r <= '0;
      largest_r    <= '0;
      best_r       <= '0;
      best_pos_r   <= '0;
      have_r       <= 1'b0;
    end else if (cmd.emit) begin
      items_seen_r <= '0;
      largest_r    <= '0;
      best_r       <= '0;
      best_pos_r   <= '0;
      have_r       <= 1'b0;
    end else begin
      if (cmd.capture && counted) begin
        items_seen_r <= items_seen_r + 1'b1;
        if (in_size > largest_r) begin
          largest_r <= in_size;
        end
      end
      if (cmd.commit && pass_r && (score > best_r)) begin
        best_r     <= score;
        best_pos_r <= pos_r;
        have_r     <= 1'b1;
      end
    end
  end

  // Output register; a held result does not stop the next blob from entering.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found_r <= found;
      index_r <= found ? best_pos_r : '0;
      count_r <= items_seen_r;
    end
  end

  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = found_r;
  assign out_tdata  = cbs_pkg::OUT_TDATA_W'({count_r, index_r});

  // A candidate exists exactly when a non-zero best score is held.
  `CBS_ASSERT_NOW(a_have_score, 1'b1, have_r == (best_r != '0))
  // The blob counter saturates at the list limit.
  `CBS_ASSERT_NOW(a_count_limit, 1'b1, items_seen_r <= cbs_pkg::CNT_W'(cbs_pkg::MAX_BLOBS))
  // A result without a match always reports position zero.
  `CBS_ASSERT_NOW(a_idx_zero, out_valid_r && !found_r, index_r == '0)

endmodule
